// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the aggregator core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AR(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== hdl/ppta_pkg.sv =====
// ---------------------------------------------------------------------------
// ppta_pkg
// Types and constants of the per-pixel temporal aggregator.
// ---------------------------------------------------------------------------
`default_nettype none

package ppta_pkg;

  localparam int IDX_W      = 16;
  localparam int VAL_W      = 16;
  localparam int ACC_W      = 24;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = ACC_W / DIV_STEPS;

  localparam logic [1:0] MODE_MIN  = 2'd0;
  localparam logic [1:0] MODE_MAX  = 2'd1;
  localparam logic [1:0] MODE_MEAN = 2'd2;

  localparam logic [1:0] CFG_MODE       = 2'd0;
  localparam logic [1:0] CFG_HAS_NODATA = 2'd1;
  localparam logic [1:0] CFG_NODATA     = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sh800000;

  localparam logic [ACC_W-1:0] POS_LIMIT = 24'd32767;
  localparam logic [ACC_W-1:0] NEG_LIMIT = 24'd32768;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             inv;
  } meta_t;

endpackage

`default_nettype wire

// ===== hdl/ppta_div.sv =====
// ---------------------------------------------------------------------------
// ppta_div
// Pipelined restoring divider: magnitude of a signed accumulator divided by
// an unsigned count, four quotient bits per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ppta_div #(
  parameter int CW = 9
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire ppta_pkg::meta_t              meta_i,
  input  wire logic signed [ppta_pkg::ACC_W-1:0] acc_i,
  input  wire logic [CW-1:0]                div_i,
  output logic                              valid_o,
  output ppta_pkg::meta_t                   meta_o,
  output logic                              neg_o,
  output logic [ppta_pkg::ACC_W-1:0]        quot_o
);
  import ppta_pkg::*;

  logic             v_q    [DIV_STAGES+1];
  meta_t            meta_q [DIV_STAGES+1];
  logic             neg_q  [DIV_STAGES+1];
  logic [ACC_W-1:0] w_q    [DIV_STAGES+1];
  logic [CW-1:0]    r_q    [DIV_STAGES+1];
  logic [CW-1:0]    d_q    [DIV_STAGES+1];

  logic [ACC_W-1:0] w_d    [DIV_STAGES+1];
  logic [CW-1:0]    r_d    [DIV_STAGES+1];

  always_comb begin : step_logic
    logic [CW-1:0]    r;
    logic [CW:0]      t;
    logic [ACC_W-1:0] w;
    logic             ge;
    w_d[0] = '0;
    r_d[0] = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = r_q[k-1];
      w = w_q[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        t  = {r, w[ACC_W-1]};
        ge = (t >= {1'b0, d_q[k-1]});
        w  = {w[ACC_W-2:0], ge};
        r  = ge ? CW'(t - {1'b0, d_q[k-1]}) : CW'(t);
      end
      w_d[k] = w;
      r_d[k] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= DIV_STAGES; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_i;
      neg_q[0]  <= acc_i[ACC_W-1];
      w_q[0]    <= acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
      r_q[0]    <= '0;
      d_q[0]    <= div_i;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        meta_q[k] <= meta_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        w_q[k]    <= w_d[k];
        r_q[k]    <= r_d[k];
        d_q[k]    <= d_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES];
  assign meta_o  = meta_q[DIV_STAGES];
  assign neg_o   = neg_q[DIV_STAGES];
  assign quot_o  = w_q[DIV_STAGES];

endmodule

`default_nettype wire

// ===== hdl/per_pixel_temporal_aggregator_core.sv =====
// ---------------------------------------------------------------------------
// per_pixel_temporal_aggregator_core
// Folds a window of frames per pixel into a minimum, maximum or mean.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata {sample, pixel_index}, tuser {last, first}, tlast
// m_axis    out        tdata {out_value, out_index}, tuser out_is_nodata
// cfg       in         cfg_index_i register index, cfg_data_i write data
//
// One request is taken every cycle while the output is not stalled.
// The accumulator memory is read when a request enters and written when it leaves
// stage 1, with the newest write forwarded to a following request for the same
// pixel. The mean uses a divider of six stages, four quotient bits each.
// All stages move together and hold while the output waits on m_axis_tready.
// The accumulator memory needs no clearing after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module per_pixel_temporal_aggregator_core #(
  parameter int PIXELS     = 65536,
  parameter int MAX_FRAMES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // pixel_index, sample
  input  wire logic [1:0]  s_axis_tuser,  // first_frame, last_frame
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_index, out_value
  output logic             m_axis_tuser,  // out_is_nodata
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import ppta_pkg::*;

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int FW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);

  logic                    adv;
  logic                    in_acc;
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_sample;
  logic                    in_first;
  logic                    in_last;
  logic                    in_range;
  logic [AW-1:0]           rd_addr;

  logic [1:0]              mode_q;
  logic                    has_nodata_q;
  logic signed [VAL_W-1:0] nodata_q;

  logic [FW-1:0]           frames_done_q, frames_done_d;
  logic [FW-1:0]           frame;
  logic [CW-1:0]           count;

  logic [ACC_W:0]          acc_mem_q [PIXELS];
  logic [ACC_W:0]          rd_q;

  logic                    s1_valid_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic [AW-1:0]           s1_addr_q;
  logic                    s1_inr_q;
  logic signed [VAL_W-1:0] s1_sample_q;
  logic                    s1_first_q;
  logic                    s1_last_q;
  logic [CW-1:0]           s1_cnt_q;

  logic                    s2_we_q;
  logic                    s2_emit_q;
  logic [IDX_W-1:0]        s2_idx_q;
  logic [AW-1:0]           s2_addr_q;
  logic signed [ACC_W-1:0] s2_acc_q;
  logic                    s2_inv_q;
  logic [CW-1:0]           s2_cnt_q;

  logic                    fwd;
  logic signed [ACC_W-1:0] base_acc;
  logic                    base_inv;
  logic                    nd;
  logic signed [ACC_W-1:0] samp_ext;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] new_acc;
  logic                    new_inv;
  logic                    mem_we;

  meta_t                   div_meta;
  logic                    div_valid;
  meta_t                   div_meta_o;
  logic                    div_neg;
  logic [ACC_W-1:0]        div_quot;
  logic [CW-1:0]           divisor;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [VAL_W-1:0]        out_val_q, out_val_d;
  logic                    out_nd_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[15:0];
  assign in_sample     = s_axis_tdata[31:16];
  assign in_first      = s_axis_tuser[0];
  assign in_last       = s_axis_tuser[1];
  assign in_range      = 32'(in_idx) < 32'(PIXELS);
  assign rd_addr       = AW'(in_idx);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_MIN;
      has_nodata_q <= 1'b0;
      nodata_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:       mode_q       <= cfg_data_i[1:0];
        CFG_HAS_NODATA: has_nodata_q <= cfg_data_i[0];
        CFG_NODATA:     nodata_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign frame = in_first ? '0 : frames_done_q;
  assign count = CW'(frame) + CW'(1);

  always_comb begin
    frames_done_d = frames_done_q;
    if (in_acc && s_axis_tlast) begin
      if (in_last) begin
        frames_done_d = '0;
      end else if (frame == FW'(MAX_FRAMES - 1)) begin
        frames_done_d = frame;
      end else begin
        frames_done_d = frame + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_done_q <= '0;
      s1_valid_q    <= 1'b0;
      s2_we_q       <= 1'b0;
      s2_emit_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      frames_done_q <= frames_done_d;
      if (adv) begin
        s1_valid_q  <= in_acc;
        s2_we_q     <= mem_we;
        s2_emit_q   <= s1_valid_q && s1_inr_q && s1_last_q;
        out_valid_q <= div_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= acc_mem_q[rd_addr];
    end
    if (mem_we) begin
      acc_mem_q[s1_addr_q] <= {new_inv, new_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_idx_q    <= in_idx;
      s1_addr_q   <= rd_addr;
      s1_inr_q    <= in_range;
      s1_sample_q <= in_sample;
      s1_first_q  <= in_first;
      s1_last_q   <= in_last;
      s1_cnt_q    <= count;
      s2_idx_q    <= s1_idx_q;
      s2_addr_q   <= s1_addr_q;
      s2_acc_q    <= new_acc;
      s2_inv_q    <= new_inv;
      s2_cnt_q    <= s1_cnt_q;
      out_idx_q   <= div_meta_o.idx;
      out_val_q   <= out_val_d;
      out_nd_q    <= div_meta_o.inv;
    end
  end

  // The request ahead has written this pixel after our read was issued.
  assign fwd      = s2_we_q && (s2_addr_q == s1_addr_q);
  assign base_acc = fwd ? s2_acc_q : rd_q[ACC_W-1:0];
  assign base_inv = fwd ? s2_inv_q : rd_q[ACC_W];
  assign nd       = has_nodata_q && (s1_sample_q == nodata_q);
  assign samp_ext = {{(ACC_W-VAL_W){s1_sample_q[VAL_W-1]}}, s1_sample_q};
  assign sum      = {base_acc[ACC_W-1], base_acc} + {samp_ext[ACC_W-1], samp_ext};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  always_comb begin
    new_acc = base_acc;
    new_inv = base_inv || nd;
    if (s1_first_q) begin
      new_acc = samp_ext;
      new_inv = nd;
    end else if (!new_inv) begin
      case (mode_q)
        MODE_MAX:  new_acc = (samp_ext > base_acc) ? samp_ext : base_acc;
        MODE_MEAN: new_acc = sum_sat;
        default:   new_acc = (samp_ext < base_acc) ? samp_ext : base_acc;
      endcase
    end
  end

  assign mem_we = adv && s1_valid_q && s1_inr_q;

  assign div_meta.idx = s2_idx_q;
  assign div_meta.inv = s2_inv_q;
  assign divisor      = (mode_q == MODE_MEAN) ? s2_cnt_q : CW'(1);

  ppta_div #(
    .CW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_emit_q),
    .meta_i  (div_meta),
    .acc_i   (s2_acc_q),
    .div_i   (divisor),
    .valid_o (div_valid),
    .meta_o  (div_meta_o),
    .neg_o   (div_neg),
    .quot_o  (div_quot)
  );

  always_comb begin
    if (div_meta_o.inv) begin
      out_val_d = nodata_q;
    end else if (div_neg) begin
      out_val_d = (div_quot > NEG_LIMIT) ? 16'h8000 : VAL_W'(-div_quot);
    end else begin
      out_val_d = (div_quot > POS_LIMIT) ? 16'h7FFF : VAL_W'(div_quot);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_val_q, out_idx_q};
  assign m_axis_tuser  = out_nd_q;

  `ASSERT_AR(a_nodata_value, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:16] == nodata_q)
  `ASSERT_AR(a_window_restart, in_acc && s_axis_tlast && in_last |=> frames_done_q == '0)
  `ASSERT_AR(a_frame_step, in_acc && s_axis_tlast && !in_last && !in_first && frames_done_q != FW'(MAX_FRAMES - 1) |=> frames_done_q == $past(frames_done_q) + FW'(1))
  `ASSERT_NEVER(a_no_write_on_stall, mem_we && !adv)

endmodule

`default_nettype wire

// ===== dv/per_pixel_temporal_aggregator_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_pixel_temporal_aggregator_core_test
// Self-checking bench for the per-pixel temporal aggregator. A short table of
// directed requests is followed by a long mean window that saturates the
// frame count and the accumulator, a window that backs up the pipeline behind
// a long output stall, and random windows of frames with random settings and
// some malformed traffic. Every result is checked field by field against the
// bench's behavioral model of the aggregator or a typed value from the table.
// ---------------------------------------------------------------------------
module per_pixel_temporal_aggregator_core_test;
  import ppta_pkg::*;

  localparam int PIX_COUNT     = 65536;
  localparam int TOP_FRAME     = 255;
  localparam int ITEM_GOAL     = 700;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  typedef struct packed {
    logic [15:0]        pix;
    logic signed [15:0] sample;
    logic               first;
    logic               last;
    logic               lastpix;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0]        idx;
    logic signed [15:0] val;
    logic               nd;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_index;
    logic [15:0] reg_data;
    pixel_item_t item;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  logic    typed_on_q;
  result_t typed_q;

  logic signed [ACC_W-1:0] running_agg [0:PIX_COUNT-1];
  logic                    pixel_void  [0:PIX_COUNT-1];
  logic [7:0]              frame_no    = '0;
  logic [1:0]              agg_mode    = MODE_MIN;
  logic                    nodata_on   = 1'b0;
  logic signed [15:0]      nodata_mark = '0;

  result_t     pending_results [$];
  stim_row_t   plan [$];
  logic [15:0] loaded_pixels [$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          gaps_on    = 1'b1;
  bit          quiet_tail = 1'b0;
  bit          hold_off_req = 1'b0;
  logic signed [15:0] gen_nodata = '0;

  per_pixel_temporal_aggregator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void apply_setting(logic [1:0] index, logic [15:0] data);
    case (index)
      CFG_MODE:       agg_mode = data[1:0];
      CFG_HAS_NODATA: nodata_on = data[0];
      CFG_NODATA:     nodata_mark = data;
      default: ;
    endcase
  endfunction

  function automatic bit fold_sample(input pixel_item_t it, output result_t res);
    int frame;
    int agg;
    int outv;
    bit marked;
    bit voided;
    frame = it.first ? 0 : int'(frame_no);
    marked = nodata_on && (it.sample == nodata_mark);
    if (it.first) begin
      agg = it.sample;
      voided = marked;
    end else begin
      agg = running_agg[it.pix];
      voided = pixel_void[it.pix] || marked;
      if (!voided) begin
        case (agg_mode)
          MODE_MAX:  if (it.sample > agg) agg = it.sample;
          MODE_MEAN: agg = clip(agg + it.sample, ACC_MIN, ACC_MAX);
          default:   if (it.sample < agg) agg = it.sample;
        endcase
      end
    end
    running_agg[it.pix] = agg[ACC_W-1:0];
    pixel_void[it.pix] = voided;
    if (voided) begin
      outv = nodata_mark;
    end else if (agg_mode == MODE_MEAN) begin
      outv = clip(agg / (frame + 1), S_MIN, S_MAX);
    end else begin
      outv = clip(agg, S_MIN, S_MAX);
    end
    res.idx = it.pix;
    res.val = outv[15:0];
    res.nd = voided;
    if (it.lastpix) begin
      frame_no = it.last ? 8'd0 : 8'(clip(frame + 1, 0, TOP_FRAME));
    end
    return it.last;
  endfunction

  always @(posedge clk_i) begin : watch
    pixel_item_t it;
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_setting(cfg_index_i, cfg_data_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.pix = s_axis_tdata[15:0];
        it.sample = s_axis_tdata[31:16];
        it.first = s_axis_tuser[0];
        it.last = s_axis_tuser[1];
        it.lastpix = s_axis_tlast;
        if (fold_sample(it, want)) begin
          pending_results.push_back(typed_on_q ? typed_q : want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx = m_axis_tdata[15:0];
        got.val = m_axis_tdata[31:16];
        got.nd = m_axis_tuser;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: index %0d value %0d nodata %0b",
                     got.idx, got.val, got.nd);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.idx !== want.idx || got.val !== want.val || got.nd !== want.nd) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: index exp %0d got %0d, value exp %0d got %0d, %s",
                       want.idx, got.idx, want.val, got.val,
                       $sformatf("nodata exp %0b got %0b", want.nd, got.nd));
            end
          end
        end
      end
    end
  end

  initial begin : receiver
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("[per_pixel_temporal_aggregator_core] ERROR");
    $finish;
  end

  task automatic offer_pixel(input pixel_item_t it, input bit typed, input result_t want);
    if (gaps_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.sample, it.pix};
    s_axis_tuser <= {it.last, it.first};
    s_axis_tlast <= it.lastpix;
    typed_on_q <= typed;
    typed_q <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_settings(input logic [1:0] mode, input logic on,
                                  input logic signed [15:0] mark);
    write_register(CFG_MODE, {14'($urandom), mode});
    write_register(CFG_HAS_NODATA, {15'($urandom), on});
    write_register(CFG_NODATA, mark);
    cfg_valid_i <= 1'b0;
    gen_nodata = mark;
  endtask

  task automatic program_random_settings();
    logic signed [15:0] mark;
    case ($urandom_range(0, 4))
      0:       mark = S_MIN;
      1:       mark = S_MAX;
      2:       mark = '0;
      default: mark = 16'($urandom);
    endcase
    program_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), mark);
  endtask

  function automatic logic signed [15:0] next_sample();
    case ($urandom_range(0, 9))
      0:       return gen_nodata;
      1:       return S_MAX;
      2:       return S_MIN;
      3, 4:    return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_window(input int npix, input int nframes, input bit broken,
                            input bit pinned, input bit press);
    logic [15:0] spots [$];
    pixel_item_t it;
    bit open_end;
    bit drop;
    open_end = broken && $urandom_range(0, 1);
    for (int p = 0; p < npix; p++) begin
      if (p > 0 && !pinned && $urandom_range(0, 5) == 0) begin
        spots.push_back(spots[p-1]);
      end else begin
        spots.push_back(16'($urandom));
      end
      loaded_pixels.push_back(spots[p]);
    end
    for (int f = 0; f < nframes; f++) begin
      if (press && f == nframes - 1) begin
        hold_off_req = 1'b1;
      end
      drop = broken && $urandom_range(0, 3) == 0;
      for (int p = 0; p < npix; p++) begin
        it.pix = spots[p];
        it.sample = pinned ? (p[0] ? S_MIN : S_MAX) : next_sample();
        it.first = (f == 0);
        it.last = (f == nframes - 1) && !open_end;
        it.lastpix = (p == npix - 1) && !drop;
        offer_pixel(it, 1'b0, '0);
      end
    end
  endtask

  function automatic void add_row_cfg(logic [1:0] index, logic [15:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_index = index;
    row.reg_data = data;
    plan.push_back(row);
  endfunction

  function automatic void add_row_item(logic [15:0] pix, int sample, bit first, bit last,
                                       bit lastpix, bit typed, int val, bit nd);
    stim_row_t row;
    row = '{default: '0};
    row.item = '{pix: pix, sample: 16'(sample), first: first, last: last, lastpix: lastpix};
    row.typed = typed;
    row.want = '{idx: pix, val: 16'(val), nd: nd};
    plan.push_back(row);
  endfunction

  initial begin : stimulus
    pixel_item_t it;
    int n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    typed_on_q = 1'b0;
    typed_q = '0;

    add_row_item(16'h0000, -32768, 1, 1, 0, 1, -32768, 0);
    add_row_item(16'hFFFF, 32767, 1, 1, 1, 1, 32767, 0);
    add_row_cfg(CFG_MODE, {14'd0, MODE_MAX});
    add_row_item(16'h5555, 100, 1, 0, 0, 0, 0, 0);
    add_row_item(16'hAAAA, -5, 1, 0, 1, 0, 0, 0);
    add_row_item(16'h5555, 200, 0, 1, 0, 0, 0, 0);
    add_row_item(16'hAAAA, -7, 0, 1, 1, 0, 0, 0);
    add_row_cfg(CFG_SPARE, 16'hFFFF);
    add_row_cfg(CFG_MODE, {14'd0, MODE_MEAN});
    add_row_item(16'h0001, 10, 1, 0, 0, 0, 0, 0);
    add_row_item(16'h0002, -10, 1, 0, 1, 0, 0, 0);
    add_row_item(16'h0001, 20, 0, 0, 0, 0, 0, 0);
    add_row_item(16'h0002, -20, 0, 0, 1, 0, 0, 0);
    add_row_item(16'h0001, -1, 0, 1, 0, 0, 0, 0);
    add_row_item(16'h0002, 1, 0, 1, 1, 0, 0, 0);
    add_row_cfg(CFG_MODE, {14'd0, MODE_SPARE});
    add_row_cfg(CFG_HAS_NODATA, 16'h0001);
    add_row_cfg(CFG_NODATA, 16'h1234);
    add_row_item(16'h0007, 16'h1234, 1, 0, 0, 0, 0, 0);
    add_row_item(16'h0008, 11, 1, 0, 0, 0, 0, 0);
    add_row_item(16'h0009, 50, 1, 0, 1, 0, 0, 0);
    add_row_item(16'h0007, 5, 0, 0, 0, 0, 0, 0);
    add_row_item(16'h0008, 16'h1234, 0, 0, 0, 0, 0, 0);
    add_row_item(16'h0009, -3, 0, 0, 1, 0, 0, 0);
    add_row_cfg(CFG_HAS_NODATA, 16'h0000);
    add_row_item(16'h0007, 1, 0, 1, 0, 1, 16'h1234, 1);
    add_row_item(16'h0008, 2, 0, 1, 0, 1, 16'h1234, 1);
    add_row_item(16'h0009, 16'h1234, 0, 1, 1, 0, 0, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle_block();
        write_register(plan[k].reg_index, plan[k].reg_data);
        cfg_valid_i <= 1'b0;
      end else begin
        offer_pixel(plan[k].item, plan[k].typed, plan[k].want);
      end
    end

    // Two pixels pinned at opposite extremes for more than 256 frames, so the
    // frame count and the running sum both saturate.
    settle_block();
    program_settings(MODE_MEAN, 1'b0, '0);
    run_window(2, 258, 1'b0, 1'b1, 1'b0);

    settle_block();
    program_random_settings();
    gaps_on = 1'b0;
    run_window(30, 2, 1'b0, 1'b0, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - 60) begin
        quiet_tail = 1'b1;
      end
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        settle_block();
        program_random_settings();
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          it.first = $urandom_range(0, 1) || loaded_pixels.size() == 0;
          it.pix = it.first ? 16'($urandom)
                            : loaded_pixels[$urandom_range(0, loaded_pixels.size() - 1)];
          if (it.first) begin
            loaded_pixels.push_back(it.pix);
          end
          it.sample = next_sample();
          it.last = $urandom_range(0, 1);
          it.lastpix = $urandom_range(0, 1);
          offer_pixel(it, 1'b0, '0);
        end
      end else begin
        run_window(($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5),
                   $urandom_range(0, 5) == 0, 1'b0, 1'b0);
      end
    end

    settle_block();
    if (mismatches == 0) begin
      $display("[per_pixel_temporal_aggregator_core] OK");
    end else begin
      $display("[per_pixel_temporal_aggregator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ppta_pkg.sv
hdl/ppta_div.sv
hdl/per_pixel_temporal_aggregator_core.sv
dv/per_pixel_temporal_aggregator_core_test.sv
